// ----- hdl/plr_pkg.sv -----
// Shared types, widths and constants of the PCM linear resampler and reblocker.
package plr_pkg;

    // Field and datapath widths
    localparam int WordW   = 32;
    localparam int SampW   = 16;
    localparam int RateW   = 18;
    localparam int PhW     = 20;
    localparam int ChunkW  = 10;
    localparam int CfgIdxW = 2;
    localparam int FmtW    = 2;

    // Result bound per input frame
    localparam int MaxResults = 16;
    localparam int CntW       = $clog2(MaxResults + 1);

    // Shared multiplier: signed MulAW x MulBW
    localparam int MulAW = 25;
    localparam int MulBW = 19;
    localparam int ProdW = MulAW + MulBW;

    // Serial divider: quotient bits and dividend magnitude width
    localparam int QuotW = SampW;
    localparam int DivNW = QuotW + RateW;

    // Single precision decode
    localparam int ExpW       = 8;
    localparam int FracW      = 23;
    localparam int DecProdW   = 39;
    localparam int ShW        = 8;
    localparam int F32Scale   = 32767;
    localparam int ExpOne     = 127;
    localparam int ExpMax     = 255;
    localparam int ShiftBase  = 150;

    // Parameter defaults and register reset values
    localparam int ChunkFramesDef = 960;
    localparam int MaxRatioDef    = 8;
    localparam int InRateRst      = 48000;
    localparam int OutRateRst     = 48000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INPUT_RATE    = 2'd0,
        CFG_OUTPUT_RATE   = 2'd1,
        CFG_MONO_SOURCE   = 2'd2,
        CFG_SAMPLE_FORMAT = 2'd3
    } t_cfg_idx;

    localparam logic [FmtW-1:0] FMT_S16 = 2'd0;
    localparam logic [FmtW-1:0] FMT_F32 = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC_MUL,
        S_DEC_SHIFT,
        S_START,
        S_LOOP,
        S_MUL_A,
        S_MUL_B,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT,
        S_COMMIT,
        S_TAIL,
        S_FIN
    } t_state;

endpackage

// ----- hdl/plr_in_if.sv -----
// Input frame channel: valid/ready handshake with two raw words and packet end.
interface plr_in_if;
    logic                       valid;
    logic                       ready;
    logic [plr_pkg::WordW-1:0]  first_word;
    logic [plr_pkg::WordW-1:0]  second_word;
    logic                       packet_end;

    modport source (output valid, output first_word, output second_word,
                    output packet_end, input ready);
    modport sink   (input valid, input first_word, input second_word,
                    input packet_end, output ready);
endinterface

// ----- hdl/plr_out_if.sv -----
// Output frame channel: valid/ready handshake with a stereo sample pair and markers.
interface plr_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [plr_pkg::SampW-1:0]  left_sample;
    logic signed [plr_pkg::SampW-1:0]  right_sample;
    logic                              chunk_end;
    logic                              run_end;

    modport source (output valid, output left_sample, output right_sample,
                    output chunk_end, output run_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input chunk_end, input run_end, output ready);
endinterface

// ----- hdl/plr_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module plr_div #(
    parameter int QW  = plr_pkg::QuotW,
    parameter int DVW = plr_pkg::RateW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QW+DVW-1:0] i_dividend,
    input  logic [DVW-1:0]    i_divisor,
    output logic              o_done,
    output logic [QW-1:0]     o_quot
);
    localparam int StepW = $clog2(QW + 1);

    logic             r_busy;
    logic [StepW-1:0] r_step;
    logic [DVW-1:0]   r_rem;
    logic [QW-1:0]    r_dd;
    logic [QW-1:0]    r_q;

    logic [DVW:0]     trial;
    logic [DVW:0]     trial_sub;
    logic             ge;

    // Upper dividend part is below the divisor, so the remainder stays in DVW bits
    always_comb begin
        trial     = {r_rem, r_dd[QW-1]};
        ge        = (trial >= {1'b0, i_divisor});
        trial_sub = trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= StepW'(QW);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[QW+DVW-1:QW];
            r_dd  <= i_dividend[QW-1:0];
        end else if (r_busy && r_step != '0) begin
            r_rem <= ge ? trial_sub[DVW-1:0] : trial[DVW-1:0];
            r_dd  <= {r_dd[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_busy && (r_step == '0);
    assign o_quot = r_q;

endmodule

// ----- hdl/pcm_linear_resampler_reblocker.sv -----
// Top level: PCM frame decoder, linear interpolating rate converter and chunk marker.
//
// Usage: input frames arrive on i_frame (valid/ready); each request carries two raw
// channel words (s16 in the low half or f32 bits) and packet_end. Stereo 16-bit
// frames at the output rate leave on o_result, each tagged with chunk_end on every
// CHUNK_FRAMES-th frame overall and run_end on the last frame caused by a request.
// Registers are written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
//
// Throughput: one frame is worked at a time; i_frame.ready is high only in idle.
// Per request: accept, then f32 decode (of the first word only with a mono source),
// per interpolated output a loop check and, for each of the two channels, a
// multiply, a multiply-accumulate, a divider launch and the divider run, then emit;
// a tail check and emit per repeated tail frame; and the start, commit and finish
// steps. The serial divider run is the longest step. The first interpolated result
// waits in the pending register and reaches the output once the next result or the
// end of work decides its run_end; at most 16 results leave per request. A stalled
// receiver holds the block in the emit or finish step.
// Reset: synchronous, active low; restores register defaults, clears history,
// phase and chunk count. No clearing pass is needed.
module pcm_linear_resampler_reblocker #(
    parameter int CHUNK_FRAMES = plr_pkg::ChunkFramesDef,
    parameter int MAX_RATIO    = plr_pkg::MaxRatioDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    plr_in_if.sink                        i_frame,
    plr_out_if.source                     o_result,
    input  logic                          i_cfg_we,
    input  logic [plr_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [plr_pkg::RateW-1:0]     i_cfg_data
);
    localparam int SampW  = plr_pkg::SampW;
    localparam int RateW  = plr_pkg::RateW;
    localparam int PhW    = plr_pkg::PhW;
    localparam int ProdW  = plr_pkg::ProdW;
    localparam int MulAW  = plr_pkg::MulAW;
    localparam int MulBW  = plr_pkg::MulBW;
    localparam int DiffW  = SampW + 1;
    localparam int RatioW = $clog2(MAX_RATIO + 1);
    localparam int LimW   = RateW + RatioW;
    localparam int ChunkW = plr_pkg::ChunkW;
    localparam int CntW   = plr_pkg::CntW;
    localparam int ExpW   = plr_pkg::ExpW;
    localparam int FracW  = plr_pkg::FracW;
    localparam int ShW    = plr_pkg::ShW;

    // Configuration
    logic [RateW-1:0]          r_in_rate;
    logic [RateW-1:0]          r_dst_rate;
    logic                      r_mono;
    logic [plr_pkg::FmtW-1:0]  r_fmt;

    // Control state
    plr_pkg::t_state r_state, n_state;
    logic                r_have_prev, n_have_prev;
    logic [RateW-1:0]    r_phase, n_phase;
    logic [ChunkW-1:0]   r_chunk, n_chunk;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic                r_out_v, n_out_v;
    logic                r_pend_v, n_pend_v;
    logic                r_stop, n_stop;
    logic                r_tail, n_tail;
    logic                r_ch, n_ch;
    logic signed [SampW-1:0] r_prev_l, n_prev_l;
    logic signed [SampW-1:0] r_prev_r, n_prev_r;

    // Datapath registers
    logic [plr_pkg::WordW-1:0] r_w0, n_w0;
    logic [plr_pkg::WordW-1:0] r_w1, n_w1;
    logic                      r_end, n_end;
    logic [PhW-1:0]            r_ph, n_ph;
    logic signed [ProdW-1:0]   r_acc, n_acc;
    logic                      r_neg, n_neg;
    logic signed [SampW-1:0]   r_cur_l, n_cur_l;
    logic signed [SampW-1:0]   r_cur_r, n_cur_r;
    logic signed [SampW-1:0]   r_res_l, n_res_l;
    logic signed [SampW-1:0]   r_res_r, n_res_r;
    logic signed [SampW-1:0]   r_pend_l, n_pend_l;
    logic signed [SampW-1:0]   r_pend_r, n_pend_r;
    logic                      r_pend_ce, n_pend_ce;
    logic signed [SampW-1:0]   r_out_l, n_out_l;
    logic signed [SampW-1:0]   r_out_r, n_out_r;
    logic                      r_out_ce, n_out_ce;
    logic                      r_out_re, n_out_re;

    // Combinational helpers
    logic                     accept;
    logic                     cfg_ok;
    logic [LimW-1:0]          rate_lim;
    logic                     out_free;
    logic [PhW-1:0]           ph_plus_ri;
    logic [PhW-1:0]           ro_ext;
    logic [PhW-1:0]           two_ro;
    logic [ChunkW-1:0]        chunk_inc;
    logic signed [SampW-1:0]  hist_a;
    logic signed [SampW-1:0]  cur_b;
    logic signed [DiffW-1:0]  diff;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [ProdW-1:0]  prod;
    logic [ProdW-1:0]         acc_mag;
    logic                     div_start;
    logic                     div_done;
    logic [SampW-1:0]         div_q;
    logic signed [SampW-1:0]  div_res;

    // f32 decode of the word of the current channel
    logic [plr_pkg::WordW-1:0] dec_word;
    logic                      dec_sign;
    logic [ExpW-1:0]           dec_exp;
    logic [FracW-1:0]          dec_frac;
    logic [FracW:0]            dec_mant;
    logic [ExpW-1:0]           dec_e;
    logic [ShW-1:0]            dec_sh;
    logic [plr_pkg::DecProdW-1:0] dec_shifted;
    logic [SampW-1:0]          dec_mag;
    logic signed [SampW-1:0]   dec_val;

    assign accept   = i_frame.valid && i_frame.ready;
    assign out_free = !r_out_v || o_result.ready;

    assign rate_lim = LimW'(r_in_rate) * LimW'(MAX_RATIO);
    assign cfg_ok   = (r_fmt == plr_pkg::FMT_S16 || r_fmt == plr_pkg::FMT_F32) &&
                      (r_in_rate != '0) && (r_dst_rate != '0) &&
                      (LimW'(r_dst_rate) <= rate_lim);

    assign ph_plus_ri = r_ph + PhW'(r_in_rate);
    assign ro_ext     = PhW'(r_dst_rate);
    assign two_ro     = PhW'({r_dst_rate, 1'b0});
    assign chunk_inc  = r_chunk + 1'b1;

    always_comb begin
        dec_word = r_ch ? r_w1 : r_w0;
        dec_sign = dec_word[plr_pkg::WordW-1];
        dec_exp  = dec_word[FracW +: ExpW];
        dec_frac = dec_word[FracW-1:0];
        dec_mant = (dec_exp != '0) ? {1'b1, dec_frac} : {1'b0, dec_frac};
        dec_e    = (dec_exp != '0) ? dec_exp : ExpW'(1);
        dec_sh   = ShW'(plr_pkg::ShiftBase) - dec_e;
        // Product m*32767 sits in the low bits of the accumulator
        dec_shifted = r_acc[plr_pkg::DecProdW-1:0] >> dec_sh;
        if (dec_exp == ExpW'(plr_pkg::ExpMax) && dec_frac != '0) begin
            dec_mag = '0;
        end else if (dec_exp >= ExpW'(plr_pkg::ExpOne)) begin
            dec_mag = SampW'(plr_pkg::F32Scale);
        end else begin
            dec_mag = dec_shifted[SampW-1:0];
        end
        dec_val = dec_sign ? -signed'(dec_mag) : signed'(dec_mag);
    end

    // Shared multiplier operand selection
    always_comb begin
        hist_a = r_ch ? r_prev_r : r_prev_l;
        cur_b  = r_ch ? r_cur_r : r_cur_l;
        diff   = DiffW'(cur_b) - DiffW'(hist_a);
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            plr_pkg::S_DEC_MUL: begin
                mul_a = signed'(MulAW'(dec_mant));
                mul_b = signed'(MulBW'(plr_pkg::F32Scale));
            end
            plr_pkg::S_MUL_A: begin
                mul_a = MulAW'(hist_a);
                mul_b = signed'(MulBW'(r_dst_rate));
            end
            plr_pkg::S_MUL_B: begin
                mul_a = MulAW'(diff);
                mul_b = signed'(MulBW'(r_ph[RateW-1:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = ProdW'(mul_a) * ProdW'(mul_b);
    end

    assign acc_mag = r_acc[ProdW-1] ? unsigned'(-r_acc) : unsigned'(r_acc);
    assign div_res = r_neg ? -signed'(div_q) : signed'(div_q);

    plr_div #(
        .QW  (plr_pkg::QuotW),
        .DVW (RateW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc_mag[plr_pkg::DivNW-1:0]),
        .i_divisor  (r_dst_rate),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_phase     = r_phase;
        n_chunk     = r_chunk;
        n_cnt       = r_cnt;
        n_out_v     = r_out_v && !o_result.ready;
        n_pend_v    = r_pend_v;
        n_stop      = r_stop;
        n_tail      = r_tail;
        n_ch        = r_ch;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_end       = r_end;
        n_ph        = r_ph;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_res_l     = r_res_l;
        n_res_r     = r_res_r;
        n_pend_l    = r_pend_l;
        n_pend_r    = r_pend_r;
        n_pend_ce   = r_pend_ce;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_ce    = r_out_ce;
        n_out_re    = r_out_re;
        div_start   = 1'b0;

        unique case (r_state)
            plr_pkg::S_IDLE: begin
                if (accept) begin
                    n_w0   = i_frame.first_word;
                    n_w1   = i_frame.second_word;
                    n_end  = i_frame.packet_end;
                    n_cnt  = '0;
                    n_stop = 1'b0;
                    n_ch   = 1'b0;
                    if (!cfg_ok) begin
                        // Drop the frame; packet end still resets the history
                        if (i_frame.packet_end) begin
                            n_have_prev = 1'b0;
                            n_phase     = '0;
                        end
                    end else if (r_fmt == plr_pkg::FMT_S16) begin
                        n_cur_l = signed'(i_frame.first_word[SampW-1:0]);
                        n_cur_r = r_mono ? signed'(i_frame.first_word[SampW-1:0])
                                         : signed'(i_frame.second_word[SampW-1:0]);
                        n_state = plr_pkg::S_START;
                    end else begin
                        n_state = plr_pkg::S_DEC_MUL;
                    end
                end
            end

            plr_pkg::S_DEC_MUL: begin
                n_acc   = prod;
                n_state = plr_pkg::S_DEC_SHIFT;
            end

            plr_pkg::S_DEC_SHIFT: begin
                if (!r_ch) begin
                    n_cur_l = dec_val;
                    if (r_mono) begin
                        n_cur_r = dec_val;
                        n_state = plr_pkg::S_START;
                    end else begin
                        n_ch    = 1'b1;
                        n_state = plr_pkg::S_DEC_MUL;
                    end
                end else begin
                    n_cur_r = dec_val;
                    n_state = plr_pkg::S_START;
                end
            end

            plr_pkg::S_START: begin
                if (r_have_prev) begin
                    n_ph    = PhW'(r_phase);
                    n_state = plr_pkg::S_LOOP;
                end else begin
                    n_ph    = '0;
                    n_state = plr_pkg::S_COMMIT;
                end
            end

            plr_pkg::S_LOOP: begin
                if (r_ph < ro_ext) begin
                    if (r_end && (ph_plus_ri > two_ro)) begin
                        // Tail would run past the packet: stop here
                        n_stop  = 1'b1;
                        n_state = plr_pkg::S_COMMIT;
                    end else begin
                        n_ch    = 1'b0;
                        n_state = plr_pkg::S_MUL_A;
                    end
                end else begin
                    n_ph    = r_ph - ro_ext;
                    n_state = plr_pkg::S_COMMIT;
                end
            end

            plr_pkg::S_MUL_A: begin
                n_acc   = prod;
                n_state = plr_pkg::S_MUL_B;
            end

            plr_pkg::S_MUL_B: begin
                n_acc   = r_acc + prod;
                n_state = plr_pkg::S_DIV_GO;
            end

            plr_pkg::S_DIV_GO: begin
                div_start = 1'b1;
                n_neg     = r_acc[ProdW-1];
                n_state   = plr_pkg::S_DIV_WAIT;
            end

            plr_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    if (!r_ch) begin
                        n_res_l = div_res;
                        n_ch    = 1'b1;
                        n_state = plr_pkg::S_MUL_A;
                    end else begin
                        n_res_r = div_res;
                        n_tail  = 1'b0;
                        n_state = plr_pkg::S_EMIT;
                    end
                end
            end

            plr_pkg::S_EMIT: begin
                if (r_cnt >= CntW'(plr_pkg::MaxResults)) begin
                    // Over the bound: drop the result, keep the phase moving
                    n_ph    = ph_plus_ri;
                    n_state = r_tail ? plr_pkg::S_TAIL : plr_pkg::S_LOOP;
                end else if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v  = 1'b1;
                        n_out_l  = r_pend_l;
                        n_out_r  = r_pend_r;
                        n_out_ce = r_pend_ce;
                        n_out_re = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend_l = r_res_l;
                    n_pend_r = r_res_r;
                    if (chunk_inc >= ChunkW'(CHUNK_FRAMES)) begin
                        n_pend_ce = 1'b1;
                        n_chunk   = '0;
                    end else begin
                        n_pend_ce = 1'b0;
                        n_chunk   = chunk_inc;
                    end
                    n_cnt   = r_cnt + 1'b1;
                    n_ph    = ph_plus_ri;
                    n_state = r_tail ? plr_pkg::S_TAIL : plr_pkg::S_LOOP;
                end
            end

            plr_pkg::S_COMMIT: begin
                n_prev_l    = r_cur_l;
                n_prev_r    = r_cur_r;
                n_have_prev = 1'b1;
                n_state     = (r_end && !r_stop) ? plr_pkg::S_TAIL : plr_pkg::S_FIN;
            end

            plr_pkg::S_TAIL: begin
                // Repeat the last frame to fill out the packet
                if (ph_plus_ri <= ro_ext) begin
                    n_res_l = r_cur_l;
                    n_res_r = r_cur_r;
                    n_tail  = 1'b1;
                    n_state = plr_pkg::S_EMIT;
                end else begin
                    n_state = plr_pkg::S_FIN;
                end
            end

            plr_pkg::S_FIN: begin
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v  = 1'b1;
                        n_out_l  = r_pend_l;
                        n_out_r  = r_pend_r;
                        n_out_ce = r_pend_ce;
                        n_out_re = 1'b1;
                        n_pend_v = 1'b0;
                    end
                    if (r_end) begin
                        n_have_prev = 1'b0;
                        n_phase     = '0;
                    end else begin
                        n_phase = r_ph[RateW-1:0];
                    end
                    n_state = plr_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = plr_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate  <= RateW'(plr_pkg::InRateRst);
            r_dst_rate <= RateW'(plr_pkg::OutRateRst);
            r_mono     <= 1'b0;
            r_fmt      <= plr_pkg::FMT_S16;
        end else if (i_cfg_we) begin
            unique case (plr_pkg::t_cfg_idx'(i_cfg_index))
                plr_pkg::CFG_INPUT_RATE:    r_in_rate  <= i_cfg_data;
                plr_pkg::CFG_OUTPUT_RATE:   r_dst_rate <= i_cfg_data;
                plr_pkg::CFG_MONO_SOURCE:   r_mono     <= i_cfg_data[0];
                plr_pkg::CFG_SAMPLE_FORMAT: r_fmt      <= i_cfg_data[plr_pkg::FmtW-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plr_pkg::S_IDLE;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
            r_chunk     <= '0;
            r_cnt       <= '0;
            r_out_v     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_stop      <= 1'b0;
            r_tail      <= 1'b0;
            r_ch        <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_phase     <= n_phase;
            r_chunk     <= n_chunk;
            r_cnt       <= n_cnt;
            r_out_v     <= n_out_v;
            r_pend_v    <= n_pend_v;
            r_stop      <= n_stop;
            r_tail      <= n_tail;
            r_ch        <= n_ch;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_w0      <= n_w0;
        r_w1      <= n_w1;
        r_end     <= n_end;
        r_ph      <= n_ph;
        r_acc     <= n_acc;
        r_neg     <= n_neg;
        r_cur_l   <= n_cur_l;
        r_cur_r   <= n_cur_r;
        r_res_l   <= n_res_l;
        r_res_r   <= n_res_r;
        r_pend_l  <= n_pend_l;
        r_pend_r  <= n_pend_r;
        r_pend_ce <= n_pend_ce;
        r_out_l   <= n_out_l;
        r_out_r   <= n_out_r;
        r_out_ce  <= n_out_ce;
        r_out_re  <= n_out_re;
    end

    assign i_frame.ready         = (r_state == plr_pkg::S_IDLE);
    assign o_result.valid        = r_out_v;
    assign o_result.left_sample  = r_out_l;
    assign o_result.right_sample = r_out_r;
    assign o_result.chunk_end    = r_out_ce;
    assign o_result.run_end      = r_out_re;

endmodule
